### rtl/core/lpht_pkg.sv
// ============================================================================
// lpht_pkg
// Shared types, constants and the modulo step for the linear-probe hash table.
// ============================================================================
`default_nettype none

package lpht_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int CAP_W  = 9;
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam int MOD_CHUNK = 8;
    localparam int MOD_STEPS = 4;
    localparam int MOD_CNT_W = 2;
    localparam int DIV_W     = MOD_CHUNK * MOD_STEPS;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SEED,
        S_PROBE,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic load_item;
        logic mod_step;
        logic seed;
        logic probe;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_last;
        logic pre_fail;
        logic probe_fin;
        logic out_free;
    } dp_sts_t;

    // Restoring remainder over one chunk of dividend bits, MSB first.
    function automatic logic [CAP_W-1:0] mod_chunk(
        input logic [CAP_W-1:0]     rem,
        input logic [MOD_CHUNK-1:0] chunk,
        input logic [CAP_W-1:0]     cap
    );
        logic [CAP_W:0]   t;
        logic [CAP_W-1:0] r;
        r = rem;
        for (int i = 0; i < MOD_CHUNK; i++) begin
            t = {r, chunk[MOD_CHUNK-1-i]};
            if (t >= {1'b0, cap}) begin
                t = t - {1'b0, cap};
            end
            r = t[CAP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/lpht_ctrl.sv
// ============================================================================
// lpht_ctrl
// Sequencer: capture, modulo, probe seed, probe walk, result hand-off.
// ============================================================================
`default_nettype none

module lpht_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire lpht_pkg::dp_sts_t sts,
    output lpht_pkg::dp_cmd_t     cmd
);

    lpht_pkg::ctrl_state_t state_reg;
    lpht_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpht_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::S_IDLE: begin
                if (in_valid) state_next = lpht_pkg::S_MOD;
            end
            lpht_pkg::S_MOD: begin
                if (sts.mod_last) state_next = lpht_pkg::S_SEED;
            end
            lpht_pkg::S_SEED: begin
                state_next = sts.pre_fail ? lpht_pkg::S_RESULT : lpht_pkg::S_PROBE;
            end
            lpht_pkg::S_PROBE: begin
                if (sts.probe_fin) state_next = lpht_pkg::S_RESULT;
            end
            lpht_pkg::S_RESULT: begin
                if (sts.out_free) state_next = lpht_pkg::S_IDLE;
            end
            default: state_next = lpht_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lpht_pkg::S_IDLE: begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            lpht_pkg::S_MOD:    cmd.mod_step = 1'b1;
            lpht_pkg::S_SEED:   cmd.seed     = 1'b1;
            lpht_pkg::S_PROBE:  cmd.probe    = 1'b1;
            lpht_pkg::S_RESULT: cmd.load_out = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/lpht_dp.sv
// ============================================================================
// lpht_dp
// Datapath: capacity register, chunked modulo, slot memories, used marks,
// entry count and result/output registers.
// ============================================================================
`default_nettype none

module lpht_dp #(
    parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [lpht_pkg::CAP_W-1:0]    cfg_wdata,
    input  wire logic                          in_kind,
    input  wire logic [lpht_pkg::KEY_W-1:0]    in_key,
    input  wire logic [lpht_pkg::VAL_W-1:0]    in_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lpht_pkg::STAT_W-1:0]        out_status,
    output logic [lpht_pkg::VAL_W-1:0]         out_result_value,
    input  wire lpht_pkg::dp_cmd_t             cmd,
    output lpht_pkg::dp_sts_t                  sts
);

    localparam int CAP_W     = lpht_pkg::CAP_W;
    localparam int CAP_LIMIT = (2 ** CAP_W) - 1;
    localparam int USE_DEPTH = (TABLE_DEPTH < CAP_LIMIT) ? TABLE_DEPTH : CAP_LIMIT;
    localparam int IDX_W     = $clog2(USE_DEPTH);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(USE_DEPTH);

    logic [CAP_W-1:0]              cap_reg;
    logic [CAP_W-1:0]              cap_eff;
    logic [CAP_W-1:0]              cap_eff_reg;
    logic                          kind_reg;
    logic [lpht_pkg::KEY_W-1:0]    key_reg;
    logic [lpht_pkg::VAL_W-1:0]    value_reg;
    logic [lpht_pkg::DIV_W-1:0]    div_reg;
    logic [CAP_W-1:0]              rem_reg;
    logic [lpht_pkg::MOD_CNT_W-1:0] step_reg;
    logic [CAP_W-1:0]              slot_reg;
    logic [CAP_W-1:0]              slot_next;
    logic [CAP_W-1:0]              slot_inc;
    logic [CAP_W-1:0]              cnt_reg;
    logic [CAP_W-1:0]              entry_count_reg;
    logic [USE_DEPTH-1:0]          used_reg;
    logic [lpht_pkg::KEY_W-1:0]    key_mem [USE_DEPTH];
    logic [lpht_pkg::VAL_W-1:0]    val_mem [USE_DEPTH];
    logic [lpht_pkg::KEY_W-1:0]    rd_key_reg;
    logic [lpht_pkg::VAL_W-1:0]    rd_val_reg;
    logic [IDX_W-1:0]              rd_addr;
    logic [IDX_W-1:0]              wr_addr;
    logic                          slot_used;
    logic                          key_match;
    logic                          last_probe;
    logic                          is_insert;
    logic                          wr_key_en;
    logic                          wr_val_en;
    lpht_pkg::status_t             res_status_reg;
    logic [lpht_pkg::VAL_W-1:0]    res_value_reg;
    logic                          out_valid_reg;
    logic [lpht_pkg::STAT_W-1:0]   out_status_reg;
    logic [lpht_pkg::VAL_W-1:0]    out_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lpht_pkg::CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    always_comb begin
        priority if (cap_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (cap_reg > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_reg;
        end
    end

    // Item capture and chunked key modulo
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg    <= in_kind;
            key_reg     <= in_key;
            value_reg   <= in_value;
            cap_eff_reg <= cap_eff;
            div_reg     <= lpht_pkg::DIV_W'(in_key);
            rem_reg     <= '0;
            step_reg    <= '0;
        end else if (cmd.mod_step) begin
            rem_reg  <= lpht_pkg::mod_chunk(rem_reg,
                            div_reg[lpht_pkg::DIV_W-1 -: lpht_pkg::MOD_CHUNK], cap_eff_reg);
            div_reg  <= div_reg << lpht_pkg::MOD_CHUNK;
            step_reg <= step_reg + 1'b1;
        end
    end

    assign is_insert  = (kind_reg == lpht_pkg::KIND_INSERT);
    assign slot_inc   = (slot_reg == cap_eff_reg - 1'b1) ? '0 : slot_reg + 1'b1;
    assign last_probe = (cnt_reg == cap_eff_reg - 1'b1);
    assign slot_used  = used_reg[IDX_W'(slot_reg)];
    assign key_match  = (rd_key_reg == key_reg);

    always_comb begin
        priority if (cmd.seed) begin
            slot_next = rem_reg;
        end else if (cmd.probe) begin
            slot_next = slot_inc;
        end else begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (cmd.seed) begin
            cnt_reg <= '0;
        end else if (cmd.probe) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign rd_addr   = IDX_W'(slot_next);
    assign wr_addr   = IDX_W'(slot_reg);
    assign wr_key_en = cmd.probe && is_insert && !slot_used;
    assign wr_val_en = cmd.probe && is_insert && (!slot_used || key_match);

    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= key_reg;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_val_en) begin
            val_mem[wr_addr] <= value_reg;
        end
        rd_val_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg        <= '0;
            entry_count_reg <= '0;
        end else if (wr_key_en) begin
            used_reg[wr_addr] <= 1'b1;
            entry_count_reg   <= entry_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed && sts.pre_fail) begin
            res_status_reg <= is_insert ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISSING;
            res_value_reg  <= '0;
        end else if (cmd.probe && sts.probe_fin) begin
            priority if (!slot_used) begin
                res_status_reg <= is_insert ? lpht_pkg::ST_INSERTED : lpht_pkg::ST_MISSING;
                res_value_reg  <= is_insert ? value_reg : '0;
            end else if (key_match) begin
                res_status_reg <= is_insert ? lpht_pkg::ST_UPDATED : lpht_pkg::ST_FOUND;
                res_value_reg  <= is_insert ? value_reg : rd_val_reg;
            end else begin
                res_status_reg <= is_insert ? lpht_pkg::ST_FULL : lpht_pkg::ST_MISSING;
                res_value_reg  <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign sts.mod_last  = (step_reg == lpht_pkg::MOD_CNT_W'(lpht_pkg::MOD_STEPS - 1));
    assign sts.pre_fail  = is_insert ? (entry_count_reg >= cap_eff_reg)
                                     : (entry_count_reg == '0);
    assign sts.probe_fin = !slot_used || key_match || last_probe;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_result_value = out_value_reg;

endmodule

`default_nettype wire

### rtl/core/linear_probe_hash_table_top.sv
// ============================================================================
// linear_probe_hash_table_top
// Open-addressing hash table with linear probing: insert/update or lookup.
// ============================================================================
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+------------------------------
//  s_       | in        | s_valid / s_ready  | s_kind, s_key, s_value
//  m_       | out       | m_valid / m_ready  | m_status, m_result_value
//  cfg_     | in        | cfg_we (no wait)   | cfg_wdata (capacity in use)
//
//  From acceptance until s_ready returns, an item passes the key modulo at 8
//  key bits per cycle, the seed of the slot memory read, one probe per cycle
//  through the registered key/value memory read port, and the hand-off to the
//  output. Full-table inserts and empty-table lookups skip the probe walk.
//  Reset clears the used marks and entry count at once; no clearing pass.
//  A stalled m_ready holds the word; the next item is taken meanwhile and
//  waits in its result stage.
// ============================================================================
`default_nettype none

module linear_probe_hash_table_top #(
    parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [lpht_pkg::CAP_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [lpht_pkg::KEY_W-1:0]    s_key,
    input  wire logic [lpht_pkg::VAL_W-1:0]    s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lpht_pkg::STAT_W-1:0]        m_status,
    output logic [lpht_pkg::VAL_W-1:0]         m_result_value
);

    lpht_pkg::dp_cmd_t cmd;
    lpht_pkg::dp_sts_t sts;

    lpht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lpht_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_kind          (s_kind),
        .in_key           (s_key),
        .in_value         (s_value),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .out_status       (m_status),
        .out_result_value (m_result_value),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

`default_nettype wire

### rtl/core/lpht_checker.sv
// ============================================================================
// lpht_checker
// Port-level checks for the linear-probe hash table, bound to the top level.
// ============================================================================
`default_nettype none

module lpht_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [lpht_pkg::STAT_W-1:0]   m_status,
    input wire logic [lpht_pkg::VAL_W-1:0]    m_result_value
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while an item is in work");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= lpht_pkg::ST_FULL))
        else $error("status code out of range");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == lpht_pkg::ST_MISSING || m_status == lpht_pkg::ST_FULL)
            |-> (m_result_value == '0))
        else $error("nonzero value on miss or full");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_result_value))
        else $error("stalled result word changed");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (.*);

`default_nettype wire
